// ----- design/nmha_pkg.sv -----
// ----------------------------------------------------------------------------
// nmha_pkg: shared types and constants of the nibble map heap allocator
// Map entry codes, command, status and strategy codes, request and result
// structs, and the control struct of the fit search unit.
// ----------------------------------------------------------------------------
package nmha_pkg;

  // default number of managed heap cells
  localparam int CELLS_DEF = 1024;

  // map entry codes
  localparam logic [3:0] ENT_FREE = 4'h0;
  localparam logic [3:0] ENT_CONT = 4'hF;

  // commands
  localparam logic [1:0] CMD_ALLOC   = 2'd0;
  localparam logic [1:0] CMD_FREE    = 2'd1;
  localparam logic [1:0] CMD_FREEALL = 2'd2;
  localparam logic [1:0] CMD_REALLOC = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_OWNER   = 2'd2;
  localparam logic [1:0] ST_REFUSED = 2'd3;

  // allocation strategies
  localparam logic [1:0] STRAT_FIRST = 2'd0;
  localparam logic [1:0] STRAT_BEST  = 2'd1;
  localparam logic [1:0] STRAT_NEXT  = 2'd2;
  localparam logic [1:0] STRAT_WORST = 2'd3;

  // configuration register indexes
  localparam logic CFG_STRATEGY = 1'b0;
  localparam logic CFG_BASE     = 1'b1;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] addr;
    logic [10:0] size;
    logic [3:0]  pid;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] result_address;
    logic        move_needed;
    logic [10:0] move_length;
  } rsp_t;

  // per-cell control of the fit search unit
  typedef struct packed {
    logic clr;
    logic step;
    logic free;
    logic last;
  } fit_ctl_t;

endpackage

// ----- design/nmha_ram.sv -----
// ----------------------------------------------------------------------------
// nmha_ram: generic single-clock RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module nmha_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/nmha_fit.sv -----
// ----------------------------------------------------------------------------
// nmha_fit: free run tracker for the allocation search
// Sees one map cell per step, tracks the current free run and keeps the
// chosen run (first, best or worst fit, ties to the lowest).
// ----------------------------------------------------------------------------
module nmha_fit #(
  parameter int CELLS = nmha_pkg::CELLS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  nmha_pkg::fit_ctl_t         ctl,
  input  logic [$clog2(CELLS)-1:0]   idx,
  input  logic [((($clog2(CELLS)+1) > 11) ? ($clog2(CELLS)+1) : 11):0] size,
  input  logic [1:0]                 mode,
  output logic                       found,
  output logic [$clog2(CELLS)-1:0]   at
);

  localparam int AW = $clog2(CELLS);
  localparam int CW = AW + 1;
  localparam int LW = ((CW > 11) ? CW : 11) + 1;

  logic          in_run;
  logic [AW-1:0] run_start;
  logic [CW-1:0] run_len;
  logic [CW-1:0] best_len;

  logic [CW-1:0] new_len;
  logic [AW-1:0] new_start;
  logic          run_end;
  logic [CW-1:0] cand_len;
  logic [AW-1:0] cand_start;
  logic          take;

  // candidate run when a run closes at a used cell or at the range end
  always_comb begin
    new_len    = in_run ? run_len + CW'(1) : CW'(1);
    new_start  = in_run ? run_start : idx;
    run_end    = ctl.step && ((ctl.free && ctl.last) || (!ctl.free && in_run));
    cand_len   = ctl.free ? new_len : run_len;
    cand_start = ctl.free ? new_start : run_start;
    take       = run_end && (LW'(cand_len) >= size) &&
                 (!found ||
                  (mode == nmha_pkg::STRAT_BEST  && cand_len < best_len) ||
                  (mode == nmha_pkg::STRAT_WORST && cand_len > best_len));
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clr) begin
      in_run <= 1'b0;
      found  <= 1'b0;
    end else if (ctl.step) begin
      in_run <= ctl.free;
      if (ctl.free) begin
        run_len   <= new_len;
        run_start <= new_start;
      end
      if (take) begin
        found    <= 1'b1;
        best_len <= cand_len;
        at       <= cand_start;
      end
    end
  end

endmodule

// ----- design/nmha_ctrl.sv -----
// ----------------------------------------------------------------------------
// nmha_ctrl: command sequencer of the allocator
// Walks the ownership map one cell per read (issue, then use the data),
// writes entries back and builds the result of each request.
// ----------------------------------------------------------------------------
module nmha_ctrl #(
  parameter int CELLS = nmha_pkg::CELLS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  nmha_pkg::req_t           req,
  output logic                     busy,
  output logic                     done,
  output nmha_pkg::rsp_t           rsp,
  input  logic [1:0]               strategy,
  input  logic [15:0]              base_address,
  output logic                     ram_we,
  output logic [$clog2(CELLS)-1:0] ram_waddr,
  output logic [3:0]               ram_wdata,
  output logic [$clog2(CELLS)-1:0] ram_raddr,
  input  logic [3:0]               ram_rdata,
  output nmha_pkg::fit_ctl_t       fit_ctl,
  output logic [$clog2(CELLS)-1:0] fit_idx,
  output logic [((($clog2(CELLS)+1) > 11) ? ($clog2(CELLS)+1) : 11):0] fit_size,
  output logic [1:0]               fit_mode,
  input  logic                     fit_found,
  input  logic [$clog2(CELLS)-1:0] fit_at
);

  localparam int AW = $clog2(CELLS);
  localparam int CW = AW + 1;
  localparam int LW = ((CW > 11) ? CW : 11) + 1;

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_HEAD   = 4'd2;
  localparam logic [3:0] S_FREE   = 4'd3;
  localparam logic [3:0] S_FALL   = 4'd4;
  localparam logic [3:0] S_LEN    = 4'd5;
  localparam logic [3:0] S_AFTER  = 4'd6;
  localparam logic [3:0] S_BEFORE = 4'd7;
  localparam logic [3:0] S_DECIDE = 4'd8;
  localparam logic [3:0] S_FITGO  = 4'd9;
  localparam logic [3:0] S_FIT    = 4'd10;
  localparam logic [3:0] S_FITEND = 4'd11;
  localparam logic [3:0] S_WRITE  = 4'd12;

  logic [3:0]    state;
  logic          pend;
  logic          live;
  logic [LW-1:0] ptr;
  logic [1:0]    cmd_r;
  logic [3:0]    pid_r;
  logic [LW-1:0] size_r;
  logic [LW-1:0] h;
  logic [LW-1:0] e;
  logic [LW-1:0] p;
  logic [LW-1:0] old;
  logic [LW-1:0] after_n;
  logic [LW-1:0] whi;
  logic [LW-1:0] wmid;
  logic          wpid;
  logic          then_free;
  logic          pass2;
  logic          in_chunk;
  logic [AW-1:0] cursor;

  logic [3:0]    v;
  logic [LW-1:0] rd_ptr;
  logic          at_end;
  logic [15:0]   idx16;
  logic          in_heap;
  logic          pid_bad;
  logic [1:0]    st_in;
  logic          walk_back;
  logic [LW-1:0] diff;
  logic [LW-1:0] before_n;
  logic [LW-1:0] p_end;

  function automatic logic [15:0] to_addr(input logic [15:0] base, input logic [LW-1:0] x);
    to_addr = base + 16'(x);
  endfunction

  always_comb begin
    v         = ram_rdata;
    rd_ptr    = (state == S_BEFORE) ? ptr - LW'(1) : ptr;
    ram_raddr = rd_ptr[AW-1:0];
    at_end    = (ptr == LW'(CELLS));
    idx16     = req.addr - base_address;
    in_heap   = ({1'b0, idx16} < 17'(CELLS));
    pid_bad   = (req.pid == nmha_pkg::ENT_FREE) || (req.pid == nmha_pkg::ENT_CONT);
    walk_back = (v == nmha_pkg::ENT_CONT) && (ptr != '0);
    diff      = size_r - old;
    before_n  = h - p;
    p_end     = p + size_r;
    busy      = (state != S_IDLE);
    done      = (state == S_IDLE) && live;
  end

  // status decided at request time; anything but ok ends the request at once
  always_comb begin
    st_in = nmha_pkg::ST_OK;
    case (req.cmd)
      nmha_pkg::CMD_ALLOC: begin
        if (pid_bad) begin
          st_in = nmha_pkg::ST_REFUSED;
        end else if (req.size == '0 || LW'(req.size) > LW'(CELLS)) begin
          st_in = nmha_pkg::ST_NOSPACE;
        end
      end
      nmha_pkg::CMD_FREE: begin
        if (!in_heap) begin
          st_in = nmha_pkg::ST_OWNER;
        end
      end
      nmha_pkg::CMD_FREEALL: st_in = nmha_pkg::ST_OK;
      default: begin
        if (pid_bad) begin
          st_in = nmha_pkg::ST_REFUSED;
        end else if (!in_heap) begin
          st_in = nmha_pkg::ST_OWNER;
        end
      end
    endcase
  end

  // map writes
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ptr[AW-1:0];
    ram_wdata = nmha_pkg::ENT_FREE;
    case (state)
      S_CLEAR: ram_we = 1'b1;
      S_HEAD:  ram_we = pend && !walk_back && (v == pid_r) &&
                        (v != nmha_pkg::ENT_FREE) && (cmd_r == nmha_pkg::CMD_FREE);
      S_FREE:  ram_we = pend && (v == nmha_pkg::ENT_CONT);
      S_FALL:  ram_we = pend && ((v == pid_r) || (in_chunk && v == nmha_pkg::ENT_CONT));
      S_WRITE: begin
        ram_we    = (ptr != whi);
        ram_wdata = wpid ? pid_r : ((ptr < wmid) ? nmha_pkg::ENT_CONT : nmha_pkg::ENT_FREE);
      end
      default: ram_we = 1'b0;
    endcase
  end

  // fit search unit control
  always_comb begin
    fit_ctl.clr  = (state == S_FITGO);
    fit_ctl.step = (state == S_FIT) && pend;
    fit_ctl.free = (v == nmha_pkg::ENT_FREE);
    fit_ctl.last = (ptr == LW'(CELLS - 1));
    fit_idx      = ptr[AW-1:0];
    fit_size     = size_r;
    fit_mode     = (strategy == nmha_pkg::STRAT_NEXT) ? nmha_pkg::STRAT_FIRST : strategy;
  end

  // a request was taken or finished at the last edge; done when back in idle
  always_ff @(posedge clk) begin
    if (rst) begin
      live <= 1'b0;
    end else begin
      live <= (state == S_IDLE) ? start : (state != S_CLEAR);
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      pend      <= 1'b0;
      ptr       <= '0;
      cursor    <= '0;
      then_free <= 1'b0;
    end else begin
      case (state)
        // clearing pass over the map after reset
        S_CLEAR: begin
          if (ptr == LW'(CELLS - 1)) begin
            state <= S_IDLE;
          end
          ptr <= ptr + LW'(1);
        end

        S_IDLE: begin
          if (start) begin
            cmd_r    <= req.cmd;
            pid_r    <= req.pid;
            size_r   <= LW'(req.size);
            rsp      <= {st_in, 16'd0, 1'b0, 11'd0};
            pend     <= 1'b0;
            pass2    <= 1'b0;
            in_chunk <= 1'b0;
            if (st_in == nmha_pkg::ST_OK) begin
              case (req.cmd)
                nmha_pkg::CMD_ALLOC: state <= S_FITGO;
                nmha_pkg::CMD_FREE: begin
                  ptr   <= LW'(idx16[AW-1:0]);
                  state <= S_HEAD;
                end
                nmha_pkg::CMD_FREEALL: begin
                  if (!pid_bad) begin
                    ptr   <= '0;
                    state <= S_FALL;
                  end
                end
                default: begin
                  ptr   <= LW'(idx16[AW-1:0]);
                  state <= S_HEAD;
                end
              endcase
            end
          end
        end

        // walk back over continuation cells to the chunk head
        S_HEAD: begin
          if (!pend) begin
            pend <= 1'b1;
          end else begin
            pend <= 1'b0;
            if (walk_back) begin
              ptr <= ptr - LW'(1);
            end else begin
              h <= ptr;
              if (v != pid_r) begin
                rsp.status <= nmha_pkg::ST_OWNER;
                state      <= S_IDLE;
              end else if (cmd_r == nmha_pkg::CMD_FREE) begin
                if (v == nmha_pkg::ENT_FREE) begin
                  state <= S_IDLE;
                end else begin
                  ptr   <= ptr + LW'(1);
                  state <= S_FREE;
                end
              end else begin
                old   <= LW'(1);
                ptr   <= ptr + LW'(1);
                state <= S_LEN;
              end
            end
          end
        end

        // free continuation cells of the chunk
        S_FREE: begin
          if (!pend && at_end) begin
            state <= S_IDLE;
          end else if (!pend) begin
            pend <= 1'b1;
          end else begin
            pend <= 1'b0;
            if (v == nmha_pkg::ENT_CONT) begin
              ptr <= ptr + LW'(1);
            end else begin
              state <= S_IDLE;
            end
          end
        end

        // free every chunk of one process
        S_FALL: begin
          if (!pend && at_end) begin
            state <= S_IDLE;
          end else if (!pend) begin
            pend <= 1'b1;
          end else begin
            pend <= 1'b0;
            ptr  <= ptr + LW'(1);
            if (v == pid_r) begin
              in_chunk <= 1'b1;
            end else if (!(in_chunk && v == nmha_pkg::ENT_CONT)) begin
              in_chunk <= 1'b0;
            end
          end
        end

        // measure the old chunk
        S_LEN: begin
          if (!pend && !at_end) begin
            pend <= 1'b1;
          end else if (pend && v == nmha_pkg::ENT_CONT) begin
            pend <= 1'b0;
            old  <= old + LW'(1);
            ptr  <= ptr + LW'(1);
          end else begin
            pend <= 1'b0;
            e    <= ptr;
            if (size_r <= old) begin
              // shrink in place
              ptr           <= h + size_r;
              wmid          <= h + size_r;
              whi           <= ptr;
              wpid          <= 1'b0;
              rsp.result_address <= to_addr(base_address, h);
              state         <= S_WRITE;
            end else begin
              after_n <= '0;
              state   <= S_AFTER;
            end
          end
        end

        // count free cells after the chunk
        S_AFTER: begin
          if (!pend && !at_end) begin
            pend <= 1'b1;
          end else if (pend && v == nmha_pkg::ENT_FREE) begin
            pend    <= 1'b0;
            after_n <= after_n + LW'(1);
            ptr     <= ptr + LW'(1);
          end else begin
            pend  <= 1'b0;
            ptr   <= h;
            state <= S_BEFORE;
          end
        end

        // find free cells before the chunk
        S_BEFORE: begin
          if (!pend && ptr != '0) begin
            pend <= 1'b1;
          end else if (pend && v == nmha_pkg::ENT_FREE) begin
            pend <= 1'b0;
            ptr  <= ptr - LW'(1);
          end else begin
            pend  <= 1'b0;
            p     <= ptr;
            state <= S_DECIDE;
          end
        end

        S_DECIDE: begin
          if (diff <= after_n) begin
            // grow into the space after
            ptr   <= e;
            wmid  <= h + size_r;
            whi   <= h + size_r;
            wpid  <= 1'b0;
            rsp.result_address <= to_addr(base_address, h);
            state <= S_WRITE;
          end else if (before_n + after_n >= diff) begin
            // slide down into the space before
            ptr   <= p;
            wmid  <= p_end;
            whi   <= (e > p_end) ? e : p_end;
            wpid  <= 1'b1;
            rsp.result_address <= to_addr(base_address, p);
            rsp.move_needed    <= 1'b1;
            rsp.move_length    <= 11'(old);
            state <= S_WRITE;
          end else if (size_r > LW'(CELLS)) begin
            rsp.status <= nmha_pkg::ST_NOSPACE;
            state      <= S_IDLE;
          end else begin
            state <= S_FITGO;
          end
        end

        S_FITGO: begin
          ptr   <= (strategy == nmha_pkg::STRAT_NEXT && !pass2) ? LW'(cursor) : '0;
          state <= S_FIT;
        end

        // free run search over the map
        S_FIT: begin
          if (!pend && at_end) begin
            state <= S_FITEND;
          end else if (!pend) begin
            pend <= 1'b1;
          end else begin
            pend <= 1'b0;
            ptr  <= ptr + LW'(1);
          end
        end

        S_FITEND: begin
          if (fit_found) begin
            if (strategy == nmha_pkg::STRAT_NEXT) begin
              cursor <= fit_at;
            end
            ptr   <= LW'(fit_at);
            wmid  <= LW'(fit_at) + size_r;
            whi   <= LW'(fit_at) + size_r;
            wpid  <= 1'b1;
            rsp.result_address <= to_addr(base_address, LW'(fit_at));
            if (cmd_r == nmha_pkg::CMD_REALLOC) begin
              rsp.move_needed <= 1'b1;
              rsp.move_length <= 11'(old);
              then_free       <= 1'b1;
            end
            state <= S_WRITE;
          end else if (strategy == nmha_pkg::STRAT_NEXT && !pass2) begin
            pass2 <= 1'b1;
            state <= S_FITGO;
          end else begin
            rsp.status <= nmha_pkg::ST_NOSPACE;
            state      <= S_IDLE;
          end
        end

        // write a range: owner, continuation up to wmid, free up to whi
        S_WRITE: begin
          if (ptr != whi) begin
            ptr  <= ptr + LW'(1);
            wpid <= 1'b0;
          end else if (then_free) begin
            ptr       <= h;
            wmid      <= h;
            whi       <= e;
            wpid      <= 1'b0;
            then_free <= 1'b0;
          end else begin
            state <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // the map is only written while a request or the clearing pass runs
  a_no_idle_write: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state != S_IDLE))
    else $error("map written while idle");

  // a map read always completes in the following cycle
  a_read_one_cycle: assert property (@(posedge clk) disable iff (rst)
    pend |=> !pend)
    else $error("read left pending");

  // a reported data move belongs to a successful request
  a_move_ok: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.move_needed) |-> (rsp.status == nmha_pkg::ST_OK))
    else $error("move reported on failure");

endmodule

// ----- design/nibble_map_heap_allocator.sv -----
// ----------------------------------------------------------------------------
// nibble_map_heap_allocator: heap allocator with a 4-bit ownership map
// Alloc, free, free-by-process and realloc over a map of CELLS entries.
// ----------------------------------------------------------------------------
//  channel   signals                             handshake
//  request   start, req (cmd addr size pid)      start & !busy
//  result    done, rsp (status addr move len)    done strobe, one cycle
//  config    cfg_valid, cfg_index, cfg_data      cfg_valid & cfg_ready
//
//  Every map cell visited is read as an address, then its data, on the single
//  read port of the map RAM; alloc scans the map once (next fit: from the
//  cursor, then again from cell 0 on a miss), realloc adds walks over the
//  chunk and its neighbors and writes one cell per cycle.
//  After reset the map is cleared one cell per cycle while busy is high.
//  Results cannot be stalled.
// ----------------------------------------------------------------------------
module nibble_map_heap_allocator #(
  parameter int CELLS = nmha_pkg::CELLS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  nmha_pkg::req_t req,
  output logic           busy,
  output logic           done,
  output nmha_pkg::rsp_t rsp,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic           cfg_index,
  input  logic [15:0]    cfg_data
);

  localparam int AW = $clog2(CELLS);
  localparam int CW = AW + 1;
  localparam int LW = ((CW > 11) ? CW : 11) + 1;

  logic [1:0]         strategy;
  logic [15:0]        base_address;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [3:0]         ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic [3:0]         ram_rdata;
  nmha_pkg::fit_ctl_t fit_ctl;
  logic [AW-1:0]      fit_idx;
  logic [LW-1:0]      fit_size;
  logic [1:0]         fit_mode;
  logic               fit_found;
  logic [AW-1:0]      fit_at;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      strategy     <= nmha_pkg::STRAT_FIRST;
      base_address <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        nmha_pkg::CFG_STRATEGY: strategy     <= cfg_data[1:0];
        default:                base_address <= cfg_data;
      endcase
    end
  end

  nmha_ctrl #(.CELLS(CELLS)) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .req          (req),
    .busy         (busy),
    .done         (done),
    .rsp          (rsp),
    .strategy     (strategy),
    .base_address (base_address),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata),
    .ram_raddr    (ram_raddr),
    .ram_rdata    (ram_rdata),
    .fit_ctl      (fit_ctl),
    .fit_idx      (fit_idx),
    .fit_size     (fit_size),
    .fit_mode     (fit_mode),
    .fit_found    (fit_found),
    .fit_at       (fit_at)
  );

  nmha_fit #(.CELLS(CELLS)) u_fit (
    .clk   (clk),
    .rst   (rst),
    .ctl   (fit_ctl),
    .idx   (fit_idx),
    .size  (fit_size),
    .mode  (fit_mode),
    .found (fit_found),
    .at    (fit_at)
  );

  nmha_ram #(.WIDTH(4), .DEPTH(CELLS)) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

// ----- bench/nibble_map_heap_allocator_tb.sv -----
// ----------------------------------------------------------------------------
// nibble_map_heap_allocator_tb: self-checking bench of the heap allocator
// Drives directed and random requests through the start/busy port, keeps its
// own copy of the ownership map to predict each result, and checks every
// done strobe field by field against the oldest expected result.
// ----------------------------------------------------------------------------
module nibble_map_heap_allocator_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NCELL = 1024;
  localparam int RAND_REQS = 270;
  localparam int STALL_LIMIT = 40 * NCELL;

  logic           clk;
  logic           rst;
  logic           start;
  nmha_pkg::req_t req;
  logic           busy;
  logic           done;
  nmha_pkg::rsp_t rsp;
  logic           cfg_valid;
  logic           cfg_ready;
  logic           cfg_index;
  logic [15:0]    cfg_data;

  nibble_map_heap_allocator dut (
    .clk(clk), .rst(rst), .start(start), .req(req), .busy(busy), .done(done),
    .rsp(rsp), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor state
  logic [3:0]  heap_map [NCELL];
  int unsigned cursor;
  logic [1:0]  mdl_strategy;
  logic [15:0] mdl_base;

  nmha_pkg::rsp_t pending_rsp [$];
  int          errors;
  int          idle_cycles = 0;

  // directed stimulus table; chk marks rows with a typed-in result
  typedef struct {
    nmha_pkg::req_t r;
    bit             chk;
    nmha_pkg::rsp_t x;
  } dir_row_t;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // free-run search from lo; mode first/best/worst
  function automatic bit fit_find(int unsigned lo, int unsigned sz, logic [1:0] mode,
                                  output int unsigned at);
    bit found;
    int unsigned best_len, i, s, len;
    found = 0;
    best_len = 0;
    at = 0;
    i = lo;
    while (i < NCELL) begin
      if (heap_map[i] != nmha_pkg::ENT_FREE) begin
        i++;
        continue;
      end
      s = i;
      while (i < NCELL && heap_map[i] == nmha_pkg::ENT_FREE) i++;
      len = i - s;
      if (len < sz) continue;
      if (!found || (mode == nmha_pkg::STRAT_BEST && len < best_len) ||
          (mode == nmha_pkg::STRAT_WORST && len > best_len)) begin
        found = 1;
        best_len = len;
        at = s;
        if (mode == nmha_pkg::STRAT_FIRST) break;
      end
    end
    return found;
  endfunction

  function automatic bit place_chunk(int unsigned sz, logic [3:0] pid,
                                     output int unsigned at);
    bit ok;
    int unsigned c;
    at = 0;
    if (sz == 0 || sz > NCELL) return 0;
    if (mdl_strategy == nmha_pkg::STRAT_NEXT) begin
      c = (cursor < NCELL) ? cursor : 0;
      ok = fit_find(c, sz, nmha_pkg::STRAT_FIRST, at);
      if (!ok) ok = fit_find(0, sz, nmha_pkg::STRAT_FIRST, at);
      if (ok) cursor = at;
    end else begin
      ok = fit_find(0, sz, mdl_strategy, at);
    end
    if (!ok) return 0;
    heap_map[at] = pid;
    for (int unsigned k = 1; k < sz; k++) heap_map[at + k] = nmha_pkg::ENT_CONT;
    return 1;
  endfunction

  function automatic int unsigned head_of(int unsigned i);
    while (i > 0 && heap_map[i] == nmha_pkg::ENT_CONT) i--;
    return i;
  endfunction

  function automatic int unsigned len_of(int unsigned h);
    int unsigned e;
    if (heap_map[h] == nmha_pkg::ENT_FREE) return 0;
    e = h + 1;
    while (e < NCELL && heap_map[e] == nmha_pkg::ENT_CONT) e++;
    return e - h;
  endfunction

  function automatic logic [15:0] cell_addr(int unsigned i);
    return 16'(mdl_base + i);
  endfunction

  // expected result of one request; updates the predictor map
  function automatic nmha_pkg::rsp_t heap_response(nmha_pkg::req_t r);
    nmha_pkg::rsp_t o;
    int unsigned idx, h, n, old, e, a, p, after, diff, before_n, nb, b;
    o = '0;
    idx = 32'(16'(r.addr - mdl_base));
    case (r.cmd)
      nmha_pkg::CMD_ALLOC: begin
        if (r.pid == nmha_pkg::ENT_FREE || r.pid == nmha_pkg::ENT_CONT)
          o.status = nmha_pkg::ST_REFUSED;
        else if (place_chunk(r.size, r.pid, b)) o.result_address = cell_addr(b);
        else o.status = nmha_pkg::ST_NOSPACE;
      end
      nmha_pkg::CMD_FREE: begin
        if (idx >= NCELL) o.status = nmha_pkg::ST_OWNER;
        else begin
          h = head_of(idx);
          if (heap_map[h] != r.pid) o.status = nmha_pkg::ST_OWNER;
          else begin
            n = len_of(h);
            for (int unsigned k = 0; k < n; k++) heap_map[h + k] = nmha_pkg::ENT_FREE;
          end
        end
      end
      nmha_pkg::CMD_FREEALL: begin
        if (r.pid != nmha_pkg::ENT_FREE && r.pid != nmha_pkg::ENT_CONT) begin
          bit in_chunk;
          in_chunk = 0;
          for (int i = 0; i < NCELL; i++) begin
            if (heap_map[i] == r.pid) begin
              in_chunk = 1;
              heap_map[i] = nmha_pkg::ENT_FREE;
            end else if (in_chunk && heap_map[i] == nmha_pkg::ENT_CONT)
              heap_map[i] = nmha_pkg::ENT_FREE;
            else in_chunk = 0;
          end
        end
      end
      default: begin
        if (r.pid == nmha_pkg::ENT_FREE || r.pid == nmha_pkg::ENT_CONT)
          o.status = nmha_pkg::ST_REFUSED;
        else if (idx >= NCELL) o.status = nmha_pkg::ST_OWNER;
        else begin
          h = head_of(idx);
          if (heap_map[h] != r.pid) o.status = nmha_pkg::ST_OWNER;
          else begin
            old = len_of(h);
            if (r.size <= old) begin
              for (int unsigned k = r.size; k < old; k++) heap_map[h + k] = nmha_pkg::ENT_FREE;
              o.result_address = cell_addr(h);
            end else begin
              e = h + old;
              a = e;
              while (a < NCELL && heap_map[a] == nmha_pkg::ENT_FREE) a++;
              after = a - e;
              diff = r.size - old;
              p = h;
              while (p > 0 && heap_map[p - 1] == nmha_pkg::ENT_FREE) p--;
              before_n = h - p;
              if (diff <= after) begin
                for (int unsigned k = e; k < h + r.size; k++) heap_map[k] = nmha_pkg::ENT_CONT;
                o.result_address = cell_addr(h);
              end else if (before_n + after >= diff) begin
                heap_map[p] = r.pid;
                for (int unsigned k = p + 1; k < p + r.size; k++)
                  heap_map[k] = nmha_pkg::ENT_CONT;
                for (int unsigned k = p + r.size; k < e; k++) heap_map[k] = nmha_pkg::ENT_FREE;
                o.result_address = cell_addr(p);
                o.move_needed = 1'b1;
                o.move_length = 11'(old);
              end else if (place_chunk(r.size, r.pid, nb)) begin
                for (int unsigned k = 0; k < old; k++) heap_map[h + k] = nmha_pkg::ENT_FREE;
                o.result_address = cell_addr(nb);
                o.move_needed = 1'b1;
                o.move_length = 11'(old);
              end else o.status = nmha_pkg::ST_NOSPACE;
            end
          end
        end
      end
    endcase
    return o;
  endfunction

  // issue one request; returns after acceptance with start still high
  task automatic send_request(nmha_pkg::req_t r, bit chk, nmha_pkg::rsp_t x);
    nmha_pkg::rsp_t p;
    p = heap_response(r);
    if (chk && p !== x) begin
      $display("%0t directed row mismatch: typed %h predicted %h", $time, x, p);
      errors++;
    end
    start <= 1'b1;
    req <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_rsp.push_back(p);
  endtask

  task automatic write_reg(logic idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == nmha_pkg::CFG_STRATEGY) mdl_strategy = val[1:0];
    else mdl_base = val;
    @(posedge clk);
  endtask

  task automatic drain;
    start <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // random gap ahead of a request, in bursts
  int burst_left;
  task automatic sender_gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 2) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  function automatic nmha_pkg::req_t random_request();
    nmha_pkg::req_t r;
    int unsigned pick;
    r.cmd = 2'($urandom_range(0, 3));
    r.pid = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(0, 15))
                                          : 4'($urandom_range(1, 6));
    pick = $urandom_range(0, 19);
    if (pick == 0) r.size = 11'($urandom_range(0, 2047));
    else if (pick == 1) r.size = 11'($urandom_range(600, 1024));
    else r.size = 11'($urandom_range(1, 80));
    // mostly addresses inside the heap
    if ($urandom_range(0, 9) == 0) r.addr = 16'($urandom);
    else r.addr = 16'(mdl_base + $urandom_range(0, NCELL - 1));
    // bias realloc/free onto cells of live chunks
    if (r.cmd != nmha_pkg::CMD_ALLOC && $urandom_range(0, 2) != 0) begin
      for (int t = 0; t < 40; t++) begin
        int unsigned c;
        c = $urandom_range(0, NCELL - 1);
        if (heap_map[c] != nmha_pkg::ENT_FREE && heap_map[c] != nmha_pkg::ENT_CONT) begin
          r.addr = cell_addr(c + $urandom_range(0, len_of(c) - 1));
          if ($urandom_range(0, 7) != 0) r.pid = heap_map[c];
          break;
        end
      end
    end
    return r;
  endfunction

  // result checker
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_rsp.size() == 0) begin
        $display("%0t unexpected result %h", $time, rsp);
        errors++;
      end else begin
        nmha_pkg::rsp_t x;
        x = pending_rsp.pop_front();
        if (rsp.status !== x.status)
          $display("%0t status: expected %0d actual %0d", $time, x.status, rsp.status);
        if (rsp.result_address !== x.result_address)
          $display("%0t result_address: expected %h actual %h", $time,
                   x.result_address, rsp.result_address);
        if (rsp.move_needed !== x.move_needed)
          $display("%0t move_needed: expected %b actual %b", $time,
                   x.move_needed, rsp.move_needed);
        if (rsp.move_length !== x.move_length)
          $display("%0t move_length: expected %0d actual %0d", $time,
                   x.move_length, rsp.move_length);
        if (rsp !== x) errors++;
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst || done || (start && !busy) || (cfg_valid && cfg_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT + 2 * NCELL) begin
      $display("** nibble_map_heap_allocator: FAILED **");
      $finish;
    end
  end

  function automatic dir_row_t row(logic [1:0] c, logic [15:0] a, logic [10:0] s,
                                   logic [3:0] p, bit chk = 0,
                                   nmha_pkg::rsp_t x = '0);
    dir_row_t d;
    d.r = '{cmd: c, addr: a, size: s, pid: p};
    d.chk = chk;
    d.x = x;
    return d;
  endfunction

  dir_row_t dir_rows [$];

  initial begin
    errors = 0;
    burst_left = 0;
    rst = 1'b1;
    start = 1'b0;
    req = '0;
    cfg_valid = 1'b0;
    cfg_index = nmha_pkg::CFG_STRATEGY;
    cfg_data = '0;
    foreach (heap_map[i]) heap_map[i] = nmha_pkg::ENT_FREE;
    cursor = 0;
    mdl_strategy = nmha_pkg::STRAT_FIRST;
    mdl_base = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: refusals, extremes, owner errors, realloc paths
    dir_rows.push_back(row(nmha_pkg::CMD_ALLOC, 0, 4, 4'h0, 1,
                           '{nmha_pkg::ST_REFUSED, 0, 0, 0}));
    dir_rows.push_back(row(nmha_pkg::CMD_ALLOC, 0, 4, 4'hF, 1,
                           '{nmha_pkg::ST_REFUSED, 0, 0, 0}));
    dir_rows.push_back(row(nmha_pkg::CMD_ALLOC, 0, 0, 4'h1, 1,
                           '{nmha_pkg::ST_NOSPACE, 0, 0, 0}));
    dir_rows.push_back(row(nmha_pkg::CMD_ALLOC, 0, 11'h7FF, 4'h1, 1,
                           '{nmha_pkg::ST_NOSPACE, 0, 0, 0}));
    dir_rows.push_back(row(nmha_pkg::CMD_ALLOC, 0, 1024, 4'hE, 1,
                           '{nmha_pkg::ST_OK, 0, 0, 0}));
    dir_rows.push_back(row(nmha_pkg::CMD_ALLOC, 0, 1, 4'h2, 1,
                           '{nmha_pkg::ST_NOSPACE, 0, 0, 0}));
    dir_rows.push_back(row(nmha_pkg::CMD_FREE, 16'd500, 0, 4'h3, 1,
                           '{nmha_pkg::ST_OWNER, 0, 0, 0}));
    dir_rows.push_back(row(nmha_pkg::CMD_FREE, 16'hFFFF, 0, 4'hE, 1,
                           '{nmha_pkg::ST_OWNER, 0, 0, 0}));
    dir_rows.push_back(row(nmha_pkg::CMD_FREE, 16'd1023, 0, 4'hE, 1,
                           '{nmha_pkg::ST_OK, 0, 0, 0}));
    dir_rows.push_back(row(nmha_pkg::CMD_FREE, 16'd7, 0, 4'h0, 1,
                           '{nmha_pkg::ST_OK, 0, 0, 0}));
    dir_rows.push_back(row(nmha_pkg::CMD_ALLOC, 0, 10, 4'h1));
    dir_rows.push_back(row(nmha_pkg::CMD_ALLOC, 0, 10, 4'h2));
    dir_rows.push_back(row(nmha_pkg::CMD_ALLOC, 0, 10, 4'h3));
    dir_rows.push_back(row(nmha_pkg::CMD_REALLOC, 16'd5, 20, 4'h0, 1,
                           '{nmha_pkg::ST_REFUSED, 0, 0, 0}));
    dir_rows.push_back(row(nmha_pkg::CMD_REALLOC, 16'd15, 20, 4'h1, 1,
                           '{nmha_pkg::ST_OWNER, 0, 0, 0}));
    dir_rows.push_back(row(nmha_pkg::CMD_REALLOC, 16'd25, 30, 4'h3));
    dir_rows.push_back(row(nmha_pkg::CMD_REALLOC, 16'd12, 4, 4'h2));
    dir_rows.push_back(row(nmha_pkg::CMD_REALLOC, 16'd20, 12, 4'h3));
    dir_rows.push_back(row(nmha_pkg::CMD_REALLOC, 16'd0, 40, 4'h1));
    dir_rows.push_back(row(nmha_pkg::CMD_REALLOC, 16'd10, 0, 4'h2));
    dir_rows.push_back(row(nmha_pkg::CMD_REALLOC, 16'd0, 2000, 4'h1));
    dir_rows.push_back(row(nmha_pkg::CMD_FREEALL, 0, 0, 4'hF, 1,
                           '{nmha_pkg::ST_OK, 0, 0, 0}));
    dir_rows.push_back(row(nmha_pkg::CMD_FREEALL, 0, 0, 4'h1, 1,
                           '{nmha_pkg::ST_OK, 0, 0, 0}));
    dir_rows.push_back(row(nmha_pkg::CMD_FREEALL, 0, 0, 4'h3, 1,
                           '{nmha_pkg::ST_OK, 0, 0, 0}));
    foreach (dir_rows[i]) send_request(dir_rows[i].r, dir_rows[i].chk, dir_rows[i].x);
    drain();

    // random phases over strategy and base settings, extremes included
    for (int ph = 0; ph < 6; ph++) begin
      logic [15:0] b;
      case (ph)
        0: b = 16'h0000;
        1: b = 16'hFFFF;
        2: b = 16'hFE00;
        default: b = 16'($urandom);
      endcase
      write_reg(nmha_pkg::CFG_STRATEGY, 16'(ph % 4));
      write_reg(nmha_pkg::CFG_BASE, b);
      for (int n = 0; n < RAND_REQS / 6; n++) begin
        sender_gap();
        send_request(random_request(), 0, '0);
      end
      drain();
    end

    if (errors == 0) $display("** nibble_map_heap_allocator: PASSED **");
    else $display("** nibble_map_heap_allocator: FAILED **");
    $finish;
  end

endmodule
